/* rtl/core/cau_pkg.sv */
// Shared types and constants of the complex arithmetic unit.
`default_nettype none

package cau_pkg;

   localparam int CAU_FIELD_W    = 32;
   localparam int CAU_CMD_W      = 3;
   localparam int CAU_STATUS_W   = 2;
   localparam int CAU_FRAC_BITS  = 16;
   localparam int CAU_DATA_WIDTH = 32;

   typedef enum logic [CAU_CMD_W-1:0] {
      CMD_ADD  = 3'd0,
      CMD_SUB  = 3'd1,
      CMD_MUL  = 3'd2,
      CMD_DIV  = 3'd3,
      CMD_CONJ = 3'd4,
      CMD_EQ   = 3'd5,
      CMD_RDIV = 3'd6,
      CMD_MOD  = 3'd7
   } cau_cmd_type;

   typedef enum logic [CAU_STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_DIV_ZERO = 2'd1,
      ST_SAT      = 2'd2
   } cau_status_type;

endpackage

`default_nettype wire

/* rtl/core/cau_req_if.sv */
// Request channel: operation code and two complex operands.
`default_nettype none

interface cau_req_if
   import cau_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic [CAU_CMD_W-1:0]   cmd;
   logic [CAU_FIELD_W-1:0] a_re;
   logic [CAU_FIELD_W-1:0] a_im;
   logic [CAU_FIELD_W-1:0] b_re;
   logic [CAU_FIELD_W-1:0] b_im;

   modport source (output valid, cmd, a_re, a_im, b_re, b_im, input ready);
   modport sink   (input valid, cmd, a_re, a_im, b_re, b_im, output ready);
endinterface

`default_nettype wire

/* rtl/core/cau_rsp_if.sv */
// Response channel: complex result, compare flag and status.
`default_nettype none

interface cau_rsp_if
   import cau_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic [CAU_FIELD_W-1:0]  out_re;
   logic [CAU_FIELD_W-1:0]  out_im;
   logic                    is_equal;
   logic [CAU_STATUS_W-1:0] status;

   modport source (output valid, out_re, out_im, is_equal, status, input ready);
   modport sink   (input valid, out_re, out_im, is_equal, status, output ready);
endinterface

`default_nettype wire

/* rtl/core/complex_arithmetic_unit.sv */
// Complex ALU in signed fixed point: operand pipeline, dividers and square root.
`default_nettype none

// Takes one request per cycle while the skid register is empty and returns one
// response per request, in order. The pipeline is four front stages (operand
// register, multipliers, adders, magnitude), a divider set-up stage, then
// DATA_WIDTH+1 restoring divider stages, one quotient bit per stage, the first
// DATA_WIDTH of which also carry the square root one result bit per stage, and
// the response register. A two-entry output (response register plus skid
// register) keeps req ready independent of rsp ready; while the skid register
// is full the whole pipeline holds. Only the low DATA_WIDTH bits of each
// operand are used and results are sign-extended to 32 bits.
module complex_arithmetic_unit
   import cau_pkg::*;
#(
   parameter int FRAC_BITS  = CAU_FRAC_BITS,
   parameter int DATA_WIDTH = CAU_DATA_WIDTH
) (
   input  wire      clock,
   input  wire      reset,
   cau_req_if.sink  req_if,
   cau_rsp_if.source rsp_if
);

   localparam int DW  = DATA_WIDTH;
   localparam int FB  = FRAC_BITS;
   localparam int MW  = 2 * DW;
   localparam int RW  = 2 * DW;
   localparam int NW  = 2 * DW + FB;
   localparam int QW  = DW + 1;
   localparam int SRW = DW + 2;

   typedef struct packed {
      logic signed [DW-1:0] val;
      logic                 ovf;
   } sat_type;

   typedef struct packed {
      logic [DW-1:0] re;
      logic [DW-1:0] im;
      logic          ovf;
      logic          eq;
   } early_type;

   typedef struct packed {
      logic            valid;
      cau_cmd_type     cmd;
      early_type       e;
      logic            dz;
      logic            neg_re;
      logic            neg_im;
      logic            big_re;
      logic            big_im;
      logic [RW-1:0]   d;
      logic [RW-1:0]   rem_re;
      logic [RW-1:0]   rem_im;
      logic [QW-1:0]   nlo_re;
      logic [QW-1:0]   nlo_im;
      logic [QW-1:0]   q_re;
      logic [QW-1:0]   q_im;
      logic [MW-1:0]   sv;
      logic [SRW-1:0]  srem;
      logic [DW-1:0]   root;
   } it_type;

   typedef struct packed {
      logic [CAU_FIELD_W-1:0] re;
      logic [CAU_FIELD_W-1:0] im;
      logic                   eq;
      cau_status_type         status;
   } rsp_type;

   function automatic sat_type sat_s(input logic signed [DW:0] x);
      sat_type r;
      r.ovf = x[DW] != x[DW-1];
      r.val = r.ovf ? {x[DW], {(DW-1){~x[DW]}}} : x[DW-1:0];
      return r;
   endfunction

   function automatic sat_type clamp_mag(input logic neg, input logic [MW-1:0] mag);
      logic [MW-1:0] lim_neg;
      logic [MW-1:0] lim_pos;
      sat_type       r;
      lim_neg = MW'(1) << (DW - 1);
      lim_pos = lim_neg - MW'(1);
      r.ovf   = 1'b0;
      if (neg) begin
         if (mag > lim_neg) begin
            r.ovf = 1'b1;
            r.val = {1'b1, {(DW-1){1'b0}}};
         end else begin
            r.val = DW'(MW'(0) - mag);
         end
      end else begin
         if (mag > lim_pos) begin
            r.ovf = 1'b1;
            r.val = {1'b0, {(DW-1){1'b1}}};
         end else begin
            r.val = mag[DW-1:0];
         end
      end
      return r;
   endfunction

   logic en;
   logic skid_valid_ff, skid_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type out_ff, out_in, skid_ff, skid_in, result;

   assign en           = ~skid_valid_ff;
   assign req_if.ready = en;

   // ---------------- stage 0: operand register
   logic                 s0_valid_ff;
   cau_cmd_type          s0_cmd_ff;
   logic signed [DW-1:0] s0_ar_ff, s0_ai_ff, s0_br_ff, s0_bi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_if.valid;
      end
      if (en) begin
         s0_cmd_ff <= cau_cmd_type'(req_if.cmd);
         s0_ar_ff  <= $signed(req_if.a_re[DW-1:0]);
         s0_ai_ff  <= $signed(req_if.a_im[DW-1:0]);
         s0_br_ff  <= $signed(req_if.b_re[DW-1:0]);
         s0_bi_ff  <= $signed(req_if.b_im[DW-1:0]);
      end
   end

   // ---------------- stage 1: multipliers and the cheap operations
   logic                 s1_valid_ff;
   cau_cmd_type          s1_cmd_ff;
   logic signed [MW-1:0] s1_prod_ff [6];
   logic signed [MW-1:0] s1_prod_in [6];
   logic signed [DW-1:0] s1_ar_ff, s1_ai_ff, s1_br_ff;
   early_type            s1_e_ff, s1_e_in;

   always_comb begin : stage1_comb
      logic signed [DW-1:0] sq_x, sq_y;
      logic signed [DW:0]   t_re, t_im;
      sat_type              c_re, c_im;
      // modulus reuses the squaring multipliers on a
      sq_x = (s0_cmd_ff == CMD_MOD) ? s0_ar_ff : s0_br_ff;
      sq_y = (s0_cmd_ff == CMD_MOD) ? s0_ai_ff : s0_bi_ff;
      s1_prod_in[0] = s0_ar_ff * s0_br_ff;
      s1_prod_in[1] = s0_ai_ff * s0_bi_ff;
      s1_prod_in[2] = s0_ai_ff * s0_br_ff;
      s1_prod_in[3] = s0_ar_ff * s0_bi_ff;
      s1_prod_in[4] = sq_x * sq_x;
      s1_prod_in[5] = sq_y * sq_y;

      t_re = (DW+1)'(s0_ar_ff);
      t_im = (DW+1)'(s0_ai_ff);
      case (s0_cmd_ff)
         CMD_ADD: begin
            t_re = (DW+1)'(s0_ar_ff) + (DW+1)'(s0_br_ff);
            t_im = (DW+1)'(s0_ai_ff) + (DW+1)'(s0_bi_ff);
         end
         CMD_SUB: begin
            t_re = (DW+1)'(s0_ar_ff) - (DW+1)'(s0_br_ff);
            t_im = (DW+1)'(s0_ai_ff) - (DW+1)'(s0_bi_ff);
         end
         CMD_CONJ: begin
            t_im = (DW+1)'(0) - (DW+1)'(s0_ai_ff);
         end
         default: begin
            t_re = '0;
            t_im = '0;
         end
      endcase
      c_re = sat_s(t_re);
      c_im = sat_s(t_im);
      s1_e_in.re  = c_re.val;
      s1_e_in.im  = c_im.val;
      s1_e_in.ovf = c_re.ovf | c_im.ovf;
      s1_e_in.eq  = (s0_cmd_ff == CMD_EQ) && (s0_ar_ff == s0_br_ff) &&
                    (s0_ai_ff == s0_bi_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= s0_valid_ff;
      end
      if (en) begin
         s1_cmd_ff  <= s0_cmd_ff;
         s1_prod_ff <= s1_prod_in;
         s1_ar_ff   <= s0_ar_ff;
         s1_ai_ff   <= s0_ai_ff;
         s1_br_ff   <= s0_br_ff;
         s1_e_ff    <= s1_e_in;
      end
   end

   // ---------------- stage 2: sums of products
   logic                 s2_valid_ff;
   cau_cmd_type          s2_cmd_ff;
   logic signed [MW:0]   s2_sre_ff, s2_sim_ff, s2_sre_in, s2_sim_in;
   logic [MW-1:0]        s2_den_ff, s2_den_in;
   logic signed [DW-1:0] s2_ar_ff, s2_ai_ff, s2_br_ff;
   early_type            s2_e_ff;

   always_comb begin
      if (s1_cmd_ff == CMD_MUL) begin
         s2_sre_in = (MW+1)'(s1_prod_ff[0]) - (MW+1)'(s1_prod_ff[1]);
         s2_sim_in = (MW+1)'(s1_prod_ff[2]) + (MW+1)'(s1_prod_ff[3]);
      end else begin
         // a * conj(b)
         s2_sre_in = (MW+1)'(s1_prod_ff[0]) + (MW+1)'(s1_prod_ff[1]);
         s2_sim_in = (MW+1)'(s1_prod_ff[2]) - (MW+1)'(s1_prod_ff[3]);
      end
      s2_den_in = MW'(s1_prod_ff[4]) + MW'(s1_prod_ff[5]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (en) begin
         s2_cmd_ff <= s1_cmd_ff;
         s2_sre_ff <= s2_sre_in;
         s2_sim_ff <= s2_sim_in;
         s2_den_ff <= s2_den_in;
         s2_ar_ff  <= s1_ar_ff;
         s2_ai_ff  <= s1_ai_ff;
         s2_br_ff  <= s1_br_ff;
         s2_e_ff   <= s1_e_ff;
      end
   end

   // ---------------- stage 3: sign and magnitude, divisor select
   logic          s3_valid_ff;
   cau_cmd_type   s3_cmd_ff;
   logic [MW-1:0] s3_mre_ff, s3_mim_ff, s3_mre_in, s3_mim_in;
   logic          s3_nre_ff, s3_nim_ff, s3_nre_in, s3_nim_in;
   logic [RW-1:0] s3_d_ff, s3_d_in;
   logic          s3_dz_ff, s3_dz_in;
   logic [MW-1:0] s3_sv_ff;
   early_type     s3_e_ff;

   always_comb begin : stage3_comb
      logic [DW-1:0] abs_ar, abs_ai, abs_br;
      abs_ar = s2_ar_ff[DW-1] ? DW'(-s2_ar_ff) : DW'(s2_ar_ff);
      abs_ai = s2_ai_ff[DW-1] ? DW'(-s2_ai_ff) : DW'(s2_ai_ff);
      abs_br = s2_br_ff[DW-1] ? DW'(-s2_br_ff) : DW'(s2_br_ff);
      if (s2_cmd_ff == CMD_RDIV) begin
         s3_mre_in = MW'(abs_ar);
         s3_mim_in = MW'(abs_ai);
         s3_nre_in = s2_ar_ff[DW-1] ^ s2_br_ff[DW-1];
         s3_nim_in = s2_ai_ff[DW-1] ^ s2_br_ff[DW-1];
         s3_d_in   = RW'(abs_br);
         s3_dz_in  = (abs_br == '0);
      end else begin
         s3_mre_in = s2_sre_ff[MW] ? MW'(-s2_sre_ff) : MW'(s2_sre_ff);
         s3_mim_in = s2_sim_ff[MW] ? MW'(-s2_sim_ff) : MW'(s2_sim_ff);
         s3_nre_in = s2_sre_ff[MW];
         s3_nim_in = s2_sim_ff[MW];
         s3_d_in   = s2_den_ff;
         s3_dz_in  = (s2_den_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (en) begin
         s3_cmd_ff <= s2_cmd_ff;
         s3_mre_ff <= s3_mre_in;
         s3_mim_ff <= s3_mim_in;
         s3_nre_ff <= s3_nre_in;
         s3_nim_ff <= s3_nim_in;
         s3_d_ff   <= s3_d_in;
         s3_dz_ff  <= s3_dz_in;
         s3_sv_ff  <= s2_den_ff;
         s3_e_ff   <= s2_e_ff;
      end
   end

   // ---------------- divider set-up and iteration stages
   it_type it_ff [QW+1];
   it_type it_in [QW+1];

   always_comb begin : setup_comb
      logic [NW-1:0] num_re, num_im, dext;
      sat_type       m_re, m_im;
      num_re = {s3_mre_ff, {FB{1'b0}}};
      num_im = {s3_mim_ff, {FB{1'b0}}};
      dext   = NW'(s3_d_ff);
      m_re   = clamp_mag(s3_nre_ff, s3_mre_ff >> FB);
      m_im   = clamp_mag(s3_nim_ff, s3_mim_ff >> FB);

      it_in[0].valid  = s3_valid_ff;
      it_in[0].cmd    = s3_cmd_ff;
      it_in[0].e      = s3_e_ff;
      if (s3_cmd_ff == CMD_MUL) begin
         it_in[0].e.re  = m_re.val;
         it_in[0].e.im  = m_im.val;
         it_in[0].e.ovf = m_re.ovf | m_im.ovf;
      end
      it_in[0].dz     = s3_dz_ff;
      it_in[0].neg_re = s3_nre_ff;
      it_in[0].neg_im = s3_nim_ff;
      // quotient would need more than QW bits: saturates for sure
      it_in[0].big_re = (num_re >> QW) >= dext;
      it_in[0].big_im = (num_im >> QW) >= dext;
      it_in[0].d      = s3_d_ff;
      it_in[0].rem_re = it_in[0].big_re ? '0 : RW'(num_re >> QW);
      it_in[0].rem_im = it_in[0].big_im ? '0 : RW'(num_im >> QW);
      it_in[0].nlo_re = num_re[QW-1:0];
      it_in[0].nlo_im = num_im[QW-1:0];
      it_in[0].q_re   = '0;
      it_in[0].q_im   = '0;
      it_in[0].sv     = s3_sv_ff;
      it_in[0].srem   = '0;
      it_in[0].root   = '0;
   end

   for (genvar k = 1; k <= QW; k++) begin : g_iter
      always_comb begin : step_comb
         logic [RW-1:0]  t_re, t_im;
         logic           ge_re, ge_im;
         logic [SRW-1:0] t_s, trial;
         logic           ge_s;
         it_in[k] = it_ff[k-1];
         t_re  = {it_ff[k-1].rem_re[RW-2:0], it_ff[k-1].nlo_re[QW-1]};
         t_im  = {it_ff[k-1].rem_im[RW-2:0], it_ff[k-1].nlo_im[QW-1]};
         ge_re = t_re >= it_ff[k-1].d;
         ge_im = t_im >= it_ff[k-1].d;
         it_in[k].rem_re = ge_re ? t_re - it_ff[k-1].d : t_re;
         it_in[k].rem_im = ge_im ? t_im - it_ff[k-1].d : t_im;
         it_in[k].q_re   = {it_ff[k-1].q_re[QW-2:0], ge_re};
         it_in[k].q_im   = {it_ff[k-1].q_im[QW-2:0], ge_im};
         it_in[k].nlo_re = it_ff[k-1].nlo_re << 1;
         it_in[k].nlo_im = it_ff[k-1].nlo_im << 1;

         // square root: one result bit per stage for the first DW stages
         t_s   = {it_ff[k-1].srem[SRW-3:0], it_ff[k-1].sv[MW-1:MW-2]};
         trial = {it_ff[k-1].root, 2'b01};
         ge_s  = t_s >= trial;
         if (k <= DW) begin
            it_in[k].srem = ge_s ? t_s - trial : t_s;
            it_in[k].root = {it_ff[k-1].root[DW-2:0], ge_s};
            it_in[k].sv   = it_ff[k-1].sv << 2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QW; k++) begin
            it_ff[k].valid <= 1'b0;
         end
      end else if (en) begin
         it_ff <= it_in;
      end
   end

   // ---------------- result select and clamp
   always_comb begin : result_comb
      sat_type c_re, c_im;
      c_re = clamp_mag(it_ff[QW].neg_re, it_ff[QW].big_re ? '1 : MW'(it_ff[QW].q_re));
      c_im = clamp_mag(it_ff[QW].neg_im, it_ff[QW].big_im ? '1 : MW'(it_ff[QW].q_im));
      result.eq = 1'b0;
      case (it_ff[QW].cmd)
         CMD_DIV, CMD_RDIV: begin
            if (it_ff[QW].dz) begin
               result.re     = '0;
               result.im     = '0;
               result.status = ST_DIV_ZERO;
            end else begin
               result.re     = CAU_FIELD_W'($signed(c_re.val));
               result.im     = CAU_FIELD_W'($signed(c_im.val));
               result.status = (c_re.ovf | c_im.ovf) ? ST_SAT : ST_OK;
            end
         end
         CMD_MOD: begin
            c_re          = clamp_mag(1'b0, MW'(it_ff[QW].root));
            result.re     = CAU_FIELD_W'($signed(c_re.val));
            result.im     = '0;
            result.status = c_re.ovf ? ST_SAT : ST_OK;
         end
         default: begin
            result.re     = CAU_FIELD_W'($signed(it_ff[QW].e.re));
            result.im     = CAU_FIELD_W'($signed(it_ff[QW].e.im));
            result.eq     = it_ff[QW].e.eq;
            result.status = it_ff[QW].e.ovf ? ST_SAT : ST_OK;
         end
      endcase
   end

   // ---------------- response register and skid register
   always_comb begin : out_comb
      logic emit, out_free;
      emit          = en & it_ff[QW].valid;
      out_free      = ~rsp_valid_ff | rsp_if.ready;
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (out_free) begin
            out_in        = skid_ff;
            rsp_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (emit) begin
         if (out_free) begin
            out_in       = result;
            rsp_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.out_re   = out_ff.re;
   assign rsp_if.out_im   = out_ff.im;
   assign rsp_if.is_equal = out_ff.eq;
   assign rsp_if.status   = out_ff.status;

`ifndef SYNTHESIS
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register full while response register empty");

   a_skid_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && !rsp_if.ready))
      else $error("skid register filled without a stalled response");

   a_dz_zero_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_ff.status == ST_DIV_ZERO) |->
      (out_ff.re == '0 && out_ff.im == '0 && !out_ff.eq))
      else $error("divide by zero response with non-zero data");

   a_eq_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_ff.eq) |->
      (out_ff.status == ST_OK && out_ff.re == '0 && out_ff.im == '0))
      else $error("compare response carries data or status");

   a_hold_when_skid: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |=> $stable(it_ff[QW]) || !$past(skid_valid_ff))
      else $error("pipeline moved while skid register full");
`endif

endmodule

`default_nettype wire
